FILE: rtl/owbm_pkg.sv
// owbm_pkg: shared types, codes and constants for the 1-Wire bus master.
// Used by one_wire_bus_master; depends on nothing else.
`default_nettype none

package owbm_pkg;

    // Field and register widths
    localparam int FUNC_W     = 3;
    localparam int DATA_W     = 8;
    localparam int DRIVE_W    = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int NUM_REGS   = 8;

    // Defaults for the top-level parameters
    localparam int DEF_READ_TAIL_TIME = 40;
    localparam int DEF_TIMER_BITS     = 10;

    // Function codes carried in each input word
    localparam logic [FUNC_W-1:0] FN_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RESET = 3'd1;
    localparam logic [FUNC_W-1:0] FN_WBIT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RBIT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_WBYTE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_RBYTE = 3'd5;

    // Line drive codes
    localparam logic [DRIVE_W-1:0] DRV_REL  = 2'd0;
    localparam logic [DRIVE_W-1:0] DRV_LOW  = 2'd1;
    localparam logic [DRIVE_W-1:0] DRV_HIGH = 2'd2;

    // Reset status codes
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STUCK   = 2'd2;

    // Configuration register indexes
    localparam int REG_RESET_LOW   = 0;
    localparam int REG_PRES_DELAY  = 1;
    localparam int REG_RESET_TAIL  = 2;
    localparam int REG_WR_START    = 3;
    localparam int REG_WR_SLOT     = 4;
    localparam int REG_WR_RECOVER  = 5;
    localparam int REG_RD_START    = 6;
    localparam int REG_RD_SAMPLE   = 7;

    // Register values after reset, in microseconds
    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        10'd600, 10'd80, 10'd600, 10'd5, 10'd60, 10'd5, 10'd10, 10'd10
    };

    // Bus phases, one-hot
    typedef enum logic [9:0] {
        PH_IDLE       = 10'b00_0000_0001,
        PH_RST_LOW    = 10'b00_0000_0010,
        PH_RST_WAIT   = 10'b00_0000_0100,
        PH_RST_TAIL   = 10'b00_0000_1000,
        PH_WR_START   = 10'b00_0001_0000,
        PH_WR_SLOT    = 10'b00_0010_0000,
        PH_WR_RECOVER = 10'b00_0100_0000,
        PH_RD_START   = 10'b00_1000_0000,
        PH_RD_DELAY   = 10'b01_0000_0000,
        PH_RD_TAIL    = 10'b10_0000_0000
    } t_phase;

    // Input word: a tick with the line level, or a command
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] data_byte;
        logic              line_level;
    } t_in_word;

    // Result word, one per input word
    typedef struct packed {
        logic [DRIVE_W-1:0]  line_drive;
        logic                busy_res;
        logic                done_res;
        logic [DATA_W-1:0]   read_value;
        logic [STATUS_W-1:0] reset_status;
    } t_out_word;

endpackage

`default_nettype wire

FILE: rtl/one_wire_bus_master.sv
// one_wire_bus_master: 1-Wire bus master sequencer with output skid stage.
// Depends on owbm_pkg.
`default_nettype none

// Each input word is either a one-microsecond tick carrying the sampled bus
// level or a command (reset, write bit/byte, read bit/byte); every word gives
// exactly one result word holding the line drive after that word, busy, done,
// the read data and the reset status. One word is taken every clock cycle
// unless input stalls: the phase sequencer updates its state when a word is
// accepted and its result is registered in the output or skid register. A
// two-entry output stage (result register plus skid register) lets input
// keep flowing while one result waits; input stalls only when both are full.
// Commands arriving while an operation runs are dropped. Timed phases last
// their programmed number of ticks, loads saturating at 2^TIMER_BITS - 1.
// Configuration writes take effect at the next phase that loads the value.
module one_wire_bus_master #(
    parameter int READ_TAIL_TIME = owbm_pkg::DEF_READ_TAIL_TIME,
    parameter int TIMER_BITS     = owbm_pkg::DEF_TIMER_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input channel
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  owbm_pkg::t_in_word                i_in_word,
    // output channel
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output owbm_pkg::t_out_word               o_out_word,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire [owbm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [owbm_pkg::CFG_W-1:0]         i_cfg_data
);
    import owbm_pkg::*;

    localparam int TIMER_MAX = (1 << TIMER_BITS) - 1;

    // Saturating load of a phase timer
    function automatic logic [TIMER_BITS-1:0] timer_load(input int unsigned t);
        int unsigned v;
        v = t;
        if (v > TIMER_MAX) begin
            v = TIMER_MAX;
        end
        return v[TIMER_BITS-1:0];
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] r_cfg [NUM_REGS];

    // Sequencer state
    t_phase                r_phase,    n_phase;
    logic [TIMER_BITS-1:0] r_timer,    n_timer;
    logic [2:0]            r_bit_cnt,  n_bit_cnt;
    logic [DATA_W-1:0]     r_shift,    n_shift;
    logic [FUNC_W-1:0]     r_kind,     n_kind;
    logic                  r_presence, n_presence;
    logic [DRIVE_W-1:0]    r_drive,    n_drive;

    // Output stage
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      r_skid_valid;
    t_out_word r_skid_word;

    t_out_word result;
    logic      in_fire;
    logic      out_free;
    logic      more_bits;

    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    assign more_bits = ((r_kind == FN_WBYTE) || (r_kind == FN_RBYTE)) && (r_bit_cnt != 3'd7);

    // Configuration writes; indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // Phase sequencer: next state and result for the current word
    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_kind     = r_kind;
        n_presence = r_presence;
        n_drive    = r_drive;
        result     = '0;

        if (i_in_word.func != FN_TICK) begin
            // commands start only from idle
            if (r_phase == PH_IDLE) begin
                unique case (i_in_word.func) inside
                    FN_RESET: begin
                        n_kind     = i_in_word.func;
                        n_bit_cnt  = '0;
                        n_presence = 1'b1;
                        n_drive    = DRV_LOW;
                        n_phase    = PH_RST_LOW;
                        n_timer    = timer_load(32'(r_cfg[REG_RESET_LOW]));
                    end
                    FN_WBIT, FN_WBYTE: begin
                        n_kind    = i_in_word.func;
                        n_bit_cnt = '0;
                        n_shift   = (i_in_word.func == FN_WBIT) ?
                                    {7'd0, i_in_word.data_byte[0]} : i_in_word.data_byte;
                        n_drive   = DRV_LOW;
                        n_phase   = PH_WR_START;
                        n_timer   = timer_load(32'(r_cfg[REG_WR_START]));
                    end
                    FN_RBIT, FN_RBYTE: begin
                        n_kind    = i_in_word.func;
                        n_bit_cnt = '0;
                        n_shift   = '0;
                        n_drive   = DRV_LOW;
                        n_phase   = PH_RD_START;
                        n_timer   = timer_load(32'(r_cfg[REG_RD_START]));
                    end
                    default: begin
                    end
                endcase
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_timer > TIMER_BITS'(1)) begin
                n_timer = r_timer - TIMER_BITS'(1);
            end else begin
                unique case (r_phase)
                    PH_RST_LOW: begin
                        n_drive = DRV_REL;
                        n_phase = PH_RST_WAIT;
                        n_timer = timer_load(32'(r_cfg[REG_PRES_DELAY]));
                    end
                    PH_RST_WAIT: begin
                        n_presence = i_in_word.line_level;
                        n_phase    = PH_RST_TAIL;
                        n_timer    = timer_load(32'(r_cfg[REG_RESET_TAIL]));
                    end
                    PH_RST_TAIL: begin
                        result.reset_status = !i_in_word.line_level ? ST_STUCK :
                                              (r_presence ? ST_ABSENT : ST_PRESENT);
                        n_presence      = 1'b1;
                        n_phase         = PH_IDLE;
                        n_timer         = '0;
                        result.done_res = 1'b1;
                    end
                    PH_WR_START: begin
                        if (r_shift[0]) begin
                            n_drive = DRV_REL;
                        end
                        n_phase = PH_WR_SLOT;
                        n_timer = timer_load(32'(r_cfg[REG_WR_SLOT]));
                    end
                    PH_WR_SLOT: begin
                        n_drive = DRV_HIGH;
                        n_phase = PH_WR_RECOVER;
                        n_timer = timer_load(32'(r_cfg[REG_WR_RECOVER]));
                    end
                    PH_WR_RECOVER: begin
                        n_shift = r_shift >> 1;
                        if (more_bits) begin
                            n_bit_cnt = r_bit_cnt + 3'd1;
                            n_drive   = DRV_LOW;
                            n_phase   = PH_WR_START;
                            n_timer   = timer_load(32'(r_cfg[REG_WR_START]));
                        end else begin
                            n_phase         = PH_IDLE;
                            n_timer         = '0;
                            result.done_res = 1'b1;
                        end
                    end
                    PH_RD_START: begin
                        n_drive = DRV_REL;
                        n_phase = PH_RD_DELAY;
                        n_timer = timer_load(32'(r_cfg[REG_RD_SAMPLE]));
                    end
                    PH_RD_DELAY: begin
                        if (i_in_word.line_level) begin
                            n_shift[r_bit_cnt] = 1'b1;
                        end
                        n_phase = PH_RD_TAIL;
                        n_timer = timer_load(32'(READ_TAIL_TIME));
                    end
                    PH_RD_TAIL: begin
                        if (more_bits) begin
                            n_bit_cnt = r_bit_cnt + 3'd1;
                            n_drive   = DRV_LOW;
                            n_phase   = PH_RD_START;
                            n_timer   = timer_load(32'(r_cfg[REG_RD_START]));
                        end else begin
                            result.read_value = r_shift;
                            n_phase           = PH_IDLE;
                            n_timer           = '0;
                            result.done_res   = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                    end
                endcase
            end
        end

        result.line_drive = n_drive;
        result.busy_res   = (n_phase != PH_IDLE);
    end

    // Sequencer state registers, updated per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit_cnt  <= '0;
            r_shift    <= '0;
            r_kind     <= FN_TICK;
            r_presence <= 1'b1;
            r_drive    <= DRV_REL;
        end else if (in_fire) begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_kind     <= n_kind;
            r_presence <= n_presence;
            r_drive    <= n_drive;
        end
    end

    // Output register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves without reset
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_word <= r_skid_valid ? r_skid_word : result;
        end else if (in_fire) begin
            r_skid_word <= result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_idle_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_timer == '0))
        else $error("phase timer nonzero while idle");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.done_res) |-> !r_out_word.busy_res)
        else $error("done word still reports busy");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.reset_status != ST_PRESENT)) |-> r_out_word.done_res)
        else $error("reset status outside a done word");

endmodule

`default_nettype wire
